FILE: hdl/set_assoc_cache_lru_controller_defines.svh
// Assertion macros for the set-associative cache controller checker.
// Used by the checker file only; no other dependencies.
`ifndef SET_ASSOC_CACHE_LRU_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SACL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sacl_pkg.sv
// Shared types, codes and constants of the set-associative cache controller.
// No dependencies.
package sacl_pkg;

  localparam int TOTAL_ENTRIES = 65536;
  localparam int MAX_WAYS      = 16;
  localparam int ADDR_BITS     = 32;
  localparam int QUEUE_DEPTH   = 4;

  localparam int TAG_W     = 30;
  localparam int AGE_W     = 4;
  localparam int ENT_IDX_W = 16;
  localparam int CNT_W     = 17;
  localparam int CFG_AW    = 4;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] POL_WB    = 2'd0;
  localparam logic [1:0] POL_WT    = 2'd1;
  localparam logic [1:0] POL_WT_NA = 2'd2;
  localparam logic [1:0] POL_RSVD  = 2'd3;

  localparam logic [1:0] REG_WAYS   = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_INDEX  = 2'd2;
  localparam logic [1:0] REG_POLICY = 2'd3;

  typedef enum logic [1:0] {K_ACC, K_FLUSH, K_NULL} kind_t;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_READ, B_LOOK, B_UPD, B_FL_RD, B_FL_WR, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [4:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic             allocated;
    logic             replaced;
    logic             dirty_writeback;
    logic             memory_write;
    logic [3:0]       way_used;
    logic [CNT_W-1:0] flushed_count;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] ways_log2;
    logic [2:0] offset_bits;
    logic [4:0] index_bits;
    logic [1:0] write_policy;
  } cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic                 is_write;
    logic [1:0]           pol;
    logic [2:0]           wlc;
    logic [ENT_IDX_W-1:0] base;
    logic [TAG_W-1:0]     tag;
    logic                 last;
  } blk_req_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

FILE: hdl/sacl_fifo.sv
// Short request queue between front and back of the cache controller.
// Depends on sacl_pkg.
module sacl_fifo #(
  parameter int DEPTH = sacl_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sacl_pkg::blk_req_t push_data,
  output logic               full,
  input  logic               pop,
  output sacl_pkg::blk_req_t pop_data,
  output logic               empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sacl_pkg::blk_req_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/sacl_front.sv
// Front end: accepts items, clamps configuration, splits runs into block requests.
// Depends on sacl_pkg; feeds sacl_fifo.
module sacl_front #(
  parameter int TOTAL_ENTRIES = sacl_pkg::TOTAL_ENTRIES,
  parameter int MAX_WAYS      = sacl_pkg::MAX_WAYS,
  parameter int ADDR_BITS     = sacl_pkg::ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sacl_pkg::cfg_t       cfg,
  input  sacl_pkg::back_stat_t stat,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sacl_pkg::in_item_t   in_data,
  output logic                 q_push,
  output sacl_pkg::blk_req_t   q_data,
  input  logic                 q_full
);
  localparam int WAY_LG = $clog2(MAX_WAYS);
  localparam logic [32:0] AM33 = (33'd1 << ADDR_BITS) - 33'd1;
  localparam logic [31:0] AMASK = AM33[31:0];
  localparam logic [19:0] ENT_MASK = 20'(TOTAL_ENTRIES - 1);

  logic              busy_r, busy_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [2:0]        last_k_r, last_k_nxt;
  sacl_pkg::kind_t   kind_r, kind_nxt;
  logic              is_write_r, is_write_nxt;
  logic [31:0]       addr_r, addr_nxt;

  logic [2:0]  wl, wlc, b;
  logic [4:0]  lim, l;
  logic [1:0]  pol;
  logic [31:0] in_addr_m;
  logic [4:0]  cnt_c, off;
  logic [5:0]  nsum;
  logic [29:0] blk, ba, amask_b;
  logic [16:0] lmask;
  logic [15:0] set_idx;
  logic [19:0] base20;
  logic        accept, is_last;

  always_comb begin
    wl   = (cfg.ways_log2 > 3'd4) ? 3'd4 : cfg.ways_log2;
    wlc  = (wl > 3'(WAY_LG)) ? 3'(WAY_LG) : wl;
    b    = (cfg.offset_bits < 3'd2) ? 3'd2 :
           ((cfg.offset_bits > 3'd5) ? 3'd5 : cfg.offset_bits);
    lim  = 5'd16 - {2'b00, wl};
    l    = (cfg.index_bits > lim) ? lim : cfg.index_bits;
    pol  = (cfg.write_policy == sacl_pkg::POL_RSVD) ? sacl_pkg::POL_WT_NA
                                                    : cfg.write_policy;

    in_addr_m = in_data.address & AMASK;
    cnt_c     = (in_data.byte_count > 5'd16) ? 5'd16 : in_data.byte_count;
    off       = 5'(in_addr_m & ((32'd1 << b) - 32'd1));
    nsum      = {1'b0, off} + {1'b0, cnt_c} - 6'd1;

    // block address of the current block of the run
    blk     = 30'(addr_r >> b);
    amask_b = 30'(AMASK >> b);
    ba      = (blk + {27'd0, k_r}) & amask_b;
    lmask   = (17'd1 << l) - 17'd1;
    set_idx = ba[15:0] & lmask[15:0];
    base20  = ({4'd0, set_idx} << wlc) & ENT_MASK;
  end

  assign in_ready = !busy_r && !stat.clearing;
  assign accept   = in_valid && in_ready;
  assign is_last  = (k_r == last_k_r);
  assign q_push   = busy_r;

  always_comb begin
    q_data          = '0;
    q_data.kind     = kind_r;
    q_data.is_write = is_write_r;
    q_data.pol      = pol;
    q_data.wlc      = wlc;
    q_data.base     = base20[sacl_pkg::ENT_IDX_W-1:0];
    q_data.tag      = ba >> l;
    q_data.last     = is_last;
  end

  always_comb begin
    busy_nxt     = busy_r;
    k_nxt        = k_r;
    last_k_nxt   = last_k_r;
    kind_nxt     = kind_r;
    is_write_nxt = is_write_r;
    addr_nxt     = addr_r;
    if (accept) begin
      busy_nxt     = 1'b1;
      k_nxt        = 3'd0;
      addr_nxt     = in_addr_m;
      is_write_nxt = (in_data.operation == sacl_pkg::OP_WRITE);
      last_k_nxt   = 3'd0;
      if (in_data.operation == sacl_pkg::OP_FLUSH) begin
        kind_nxt = sacl_pkg::K_FLUSH;
      end else if (in_data.operation == sacl_pkg::OP_NONE ||
                   in_data.byte_count == 5'd0) begin
        kind_nxt = sacl_pkg::K_NULL;
      end else begin
        kind_nxt   = sacl_pkg::K_ACC;
        last_k_nxt = 3'(nsum >> b);
      end
    end else if (busy_r && !q_full) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_k_r   <= last_k_nxt;
    kind_r     <= kind_nxt;
    is_write_r <= is_write_nxt;
    addr_r     <= addr_nxt;
  end

endmodule

FILE: hdl/sacl_back.sv
// Back end: set-row memory, lookup, LRU update, flush walk and clearing pass.
// Depends on sacl_pkg; drains sacl_fifo and drives the result register.
module sacl_back #(
  parameter int TOTAL_ENTRIES = sacl_pkg::TOTAL_ENTRIES,
  parameter int MAX_WAYS      = sacl_pkg::MAX_WAYS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 q_pop,
  input  sacl_pkg::blk_req_t   q_data,
  input  logic                 q_empty,
  output sacl_pkg::back_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sacl_pkg::out_item_t  out_data
);
  localparam int ROWS   = TOTAL_ENTRIES / MAX_WAYS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WAY_LG = $clog2(MAX_WAYS);
  localparam int LANE_W = (WAY_LG > 0) ? WAY_LG : 1;
  localparam int AGE_W  = sacl_pkg::AGE_W;

  typedef struct packed {
    logic              hit;
    logic              alloc;
    logic              repl;
    logic              wb;
    logic              touched;
    logic [LANE_W-1:0] lane;
  } look_t;

  sacl_pkg::entry_t [MAX_WAYS-1:0] row_mem [ROWS];
  sacl_pkg::entry_t [MAX_WAYS-1:0] rd_row_r, new_row, clr_row, fl_row, mem_wdata;

  sacl_pkg::back_state_t state_r, state_nxt;
  sacl_pkg::blk_req_t    req_r, req_nxt;
  look_t                 look_r, look_nxt, look_c;
  logic [ROW_AW-1:0]     row_ctr_r, row_ctr_nxt, row_a, mem_waddr, mem_raddr;
  logic [sacl_pkg::CNT_W-1:0] fcount_r, fcount_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sacl_pkg::out_item_t   out_res_r, out_res_nxt, emit_res;
  logic                  emit, out_free, mem_we, mem_re, row_last, noalloc, pol_wb;

  logic [LANE_W-1:0] lane0, hit_lane, inv_lane, lane_off;
  logic [MAX_WAYS-1:0] act, hv, iv;
  logic [AGE_W:0]    key  [MAX_WAYS];
  logic [LANE_W-1:0] kidx [MAX_WAYS];
  logic [AGE_W-1:0]  touch_age;
  logic [$clog2(MAX_WAYS+1)-1:0] fl_cnt;

  assign stat.clearing = (state_r == sacl_pkg::B_CLEAR);
  assign out_valid     = out_valid_r;
  assign out_data      = out_res_r;
  assign out_free      = !out_valid_r || out_ready;
  assign row_a         = ROW_AW'(req_r.base >> WAY_LG);
  assign lane0         = LANE_W'(req_r.base) & LANE_W'(MAX_WAYS - 1);
  assign row_last      = (row_ctr_r == ROW_AW'(ROWS - 1));
  assign noalloc       = req_r.is_write && (req_r.pol == sacl_pkg::POL_WT_NA);
  assign pol_wb        = req_r.is_write && (req_r.pol == sacl_pkg::POL_WB);

  // lookup on the registered set row
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      act[i] = (((LANE_W'(i) ^ lane0) >> req_r.wlc) == '0);
      hv[i]  = act[i] && rd_row_r[i].valid && (rd_row_r[i].tag == req_r.tag);
      iv[i]  = act[i] && !rd_row_r[i].valid;
    end
    hit_lane = '0;
    inv_lane = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hv[i]) hit_lane = LANE_W'(i);
      if (iv[i]) inv_lane = LANE_W'(i);
    end
    // oldest active way, lowest way wins a tie
    for (int i = 0; i < MAX_WAYS; i++) begin
      key[i]  = {act[i], rd_row_r[i].age};
      kidx[i] = LANE_W'(i);
    end
    for (int s = 1; s < MAX_WAYS; s = s * 2) begin
      for (int i = 0; i + s < MAX_WAYS; i = i + 2 * s) begin
        if (key[i+s] > key[i]) begin
          key[i]  = key[i+s];
          kidx[i] = kidx[i+s];
        end
      end
    end
    look_c = '0;
    if (|hv) begin
      look_c.hit     = 1'b1;
      look_c.touched = 1'b1;
      look_c.lane    = hit_lane;
    end else if (!noalloc) begin
      look_c.alloc   = 1'b1;
      look_c.touched = 1'b1;
      if (|iv) begin
        look_c.lane = inv_lane;
      end else begin
        look_c.lane = kidx[0];
        look_c.repl = 1'b1;
        look_c.wb   = rd_row_r[kidx[0]].dirty;
      end
    end
  end

  // updated set row
  always_comb begin
    new_row   = rd_row_r;
    touch_age = rd_row_r[look_r.lane].age;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (act[i] && rd_row_r[i].age < touch_age) begin
        new_row[i].age = rd_row_r[i].age + AGE_W'(1);
      end
    end
    new_row[look_r.lane].age = '0;
    if (look_r.alloc) begin
      new_row[look_r.lane].valid = 1'b1;
      new_row[look_r.lane].tag   = req_r.tag;
      new_row[look_r.lane].dirty = pol_wb;
    end else if (look_r.hit && pol_wb) begin
      new_row[look_r.lane].dirty = 1'b1;
    end
    lane_off = look_r.lane - lane0;
  end

  always_comb begin
    fl_row = rd_row_r;
    fl_cnt = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      clr_row[i]       = '0;
      clr_row[i].age   = AGE_W'(i);
      fl_cnt           = fl_cnt + ($bits(fl_cnt))'(rd_row_r[i].valid && rd_row_r[i].dirty);
      if (rd_row_r[i].valid) fl_row[i].dirty = 1'b0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    row_ctr_nxt = row_ctr_r;
    fcount_nxt  = fcount_r;
    look_nxt    = look_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = row_a;
    mem_raddr   = row_a;
    mem_wdata   = new_row;
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_res    = '0;
    case (state_r)
      sacl_pkg::B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = row_ctr_r;
        mem_wdata = clr_row;
        if (row_last) begin
          row_ctr_nxt = '0;
          state_nxt   = sacl_pkg::B_IDLE;
        end else begin
          row_ctr_nxt = row_ctr_r + ROW_AW'(1);
        end
      end
      sacl_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          req_nxt = q_data;
          case (q_data.kind)
            sacl_pkg::K_ACC:   state_nxt = sacl_pkg::B_READ;
            sacl_pkg::K_FLUSH: begin
              row_ctr_nxt = '0;
              fcount_nxt  = '0;
              state_nxt   = sacl_pkg::B_FL_RD;
            end
            default: begin
              fcount_nxt = '0;
              state_nxt  = sacl_pkg::B_DONE;
            end
          endcase
        end
      end
      sacl_pkg::B_READ: begin
        mem_re    = 1'b1;
        state_nxt = sacl_pkg::B_LOOK;
      end
      sacl_pkg::B_LOOK: begin
        look_nxt  = look_c;
        state_nxt = sacl_pkg::B_UPD;
      end
      sacl_pkg::B_UPD: begin
        if (out_free) begin
          emit                     = 1'b1;
          emit_res.hit             = look_r.hit;
          emit_res.allocated       = look_r.alloc;
          emit_res.replaced        = look_r.repl;
          emit_res.dirty_writeback = look_r.wb;
          emit_res.memory_write    = req_r.is_write && (req_r.pol != sacl_pkg::POL_WB);
          emit_res.way_used        = look_r.touched ? 4'(lane_off) : 4'd0;
          emit_res.last            = req_r.last;
          mem_we                   = look_r.touched;
          state_nxt                = sacl_pkg::B_IDLE;
        end
      end
      sacl_pkg::B_FL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = row_ctr_r;
        state_nxt = sacl_pkg::B_FL_WR;
      end
      sacl_pkg::B_FL_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = row_ctr_r;
        mem_wdata  = fl_row;
        fcount_nxt = fcount_r + sacl_pkg::CNT_W'(fl_cnt);
        if (row_last) begin
          state_nxt = sacl_pkg::B_DONE;
        end else begin
          row_ctr_nxt = row_ctr_r + ROW_AW'(1);
          state_nxt   = sacl_pkg::B_FL_RD;
        end
      end
      sacl_pkg::B_DONE: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_res.flushed_count = fcount_r;
          emit_res.last          = 1'b1;
          state_nxt              = sacl_pkg::B_IDLE;
        end
      end
      default: state_nxt = sacl_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = emit_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sacl_pkg::B_CLEAR;
      row_ctr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_ctr_r   <= row_ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    look_r    <= look_nxt;
    fcount_r  <= fcount_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= row_mem[mem_raddr];
    end
  end

endmodule

FILE: hdl/set_assoc_cache_lru_controller.sv
// Top level of the set-associative cache tag/state controller with true LRU.
// Depends on sacl_pkg, sacl_front, sacl_fifo and sacl_back.
//
// Tags, valid and dirty marks and ages live in one memory of TOTAL_ENTRIES/MAX_WAYS
// rows, one row holding MAX_WAYS ways, so any set is a single row. A front end
// accepts an item and splits it into one to five block requests, one per cycle
// while the queue is not full, into a short queue; the back end takes each request
// through pop, row read, lookup and row write-back with result, one request at a
// time. The next item is taken once its last block is queued. A flush walks every
// row, reading and then writing back each row. After reset a clearing pass writes
// every row, during which in_ready stays low; configuration writes are taken
// throughout. Configuration registers sit at byte addresses 0, 4, 8 and 12.
module set_assoc_cache_lru_controller #(
  parameter int TOTAL_ENTRIES = sacl_pkg::TOTAL_ENTRIES,
  parameter int MAX_WAYS      = sacl_pkg::MAX_WAYS,
  parameter int ADDR_BITS     = sacl_pkg::ADDR_BITS,
  parameter int QUEUE_DEPTH   = sacl_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sacl_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sacl_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sacl_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  sacl_pkg::cfg_t       cfg_r;
  sacl_pkg::back_stat_t stat;
  sacl_pkg::blk_req_t   push_data, pop_data;
  logic push, full, pop, empty, cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ways_log2    <= 3'd0;
      cfg_r.offset_bits  <= 3'd2;
      cfg_r.index_bits   <= 5'd16;
      cfg_r.write_policy <= sacl_pkg::POL_WB;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        sacl_pkg::REG_WAYS:   cfg_r.ways_log2    <= cfg_pwdata[2:0];
        sacl_pkg::REG_OFFSET: cfg_r.offset_bits  <= cfg_pwdata[2:0];
        sacl_pkg::REG_INDEX:  cfg_r.index_bits   <= cfg_pwdata[4:0];
        sacl_pkg::REG_POLICY: cfg_r.write_policy <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      sacl_pkg::REG_WAYS:   cfg_prdata = {29'd0, cfg_r.ways_log2};
      sacl_pkg::REG_OFFSET: cfg_prdata = {29'd0, cfg_r.offset_bits};
      sacl_pkg::REG_INDEX:  cfg_prdata = {27'd0, cfg_r.index_bits};
      sacl_pkg::REG_POLICY: cfg_prdata = {30'd0, cfg_r.write_policy};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  sacl_front #(
    .TOTAL_ENTRIES(TOTAL_ENTRIES),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .stat    (stat),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_push  (push),
    .q_data  (push_data),
    .q_full  (full)
  );

  sacl_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  sacl_back #(
    .TOTAL_ENTRIES(TOTAL_ENTRIES),
    .MAX_WAYS     (MAX_WAYS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_pop    (pop),
    .q_data   (pop_data),
    .q_empty  (empty),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

FILE: hdl/sacl_checker.sv
// Port-level checker for the set-associative cache controller, with its bind.
// Depends on sacl_pkg and set_assoc_cache_lru_controller_defines.svh.
`include "set_assoc_cache_lru_controller_defines.svh"

module sacl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input sacl_pkg::out_item_t out_data
);
  logic stall, wb_ante, wb_cons, hit_ante, hit_cons, fl_ante, fl_cons;

  assign stall    = out_valid && !out_ready;
  assign wb_ante  = out_valid && out_data.dirty_writeback;
  assign wb_cons  = out_data.replaced && out_data.allocated && !out_data.hit;
  assign hit_ante = out_valid && out_data.hit;
  assign hit_cons = !out_data.allocated && !out_data.replaced;
  assign fl_ante  = out_valid && (out_data.flushed_count != 17'd0);
  assign fl_cons  = out_data.last && !out_data.hit && !out_data.allocated &&
                    (out_data.way_used == 4'd0);

  `SACL_ASSERT_NEXT(a_out_hold, stall, out_valid, "result item dropped while stalled")

  `SACL_ASSERT_SAME(a_wb_repl, wb_ante, wb_cons, "writeback without replacement")

  `SACL_ASSERT_SAME(a_hit_alloc, hit_ante, hit_cons, "hit item also allocated")

  `SACL_ASSERT_SAME(a_flush_res, fl_ante, fl_cons, "flush item carries access events")

endmodule

bind set_assoc_cache_lru_controller sacl_checker u_sacl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

FILE: tb/sv/tb_top.sv
// Testbench of the set-associative cache tag/state controller: random and
// directed accesses checked item by item against a behavioral cache model.
// Depends on sacl_pkg and the set_assoc_cache_lru_controller RTL.
`timescale 1ns / 1ps

class cache_scoreboard;
  bit [29:0]  tags[sacl_pkg::TOTAL_ENTRIES];
  bit         valids[sacl_pkg::TOTAL_ENTRIES];
  bit         dirties[sacl_pkg::TOTAL_ENTRIES];
  bit [3:0]   ages[sacl_pkg::TOTAL_ENTRIES];
  bit [2:0]   ways_log2;
  bit [2:0]   offset_bits;
  bit [4:0]   index_bits;
  bit [1:0]   write_policy;
  sacl_pkg::out_item_t expected_q[$];
  int         errors;

  function new();
    for (int e = 0; e < sacl_pkg::TOTAL_ENTRIES; e++) ages[e] = 4'(e % sacl_pkg::MAX_WAYS);
    ways_log2 = 0;
    offset_bits = 2;
    index_bits = 16;
    write_policy = sacl_pkg::POL_WB;
    errors = 0;
  endfunction

  function void set_reg(bit [1:0] idx, bit [31:0] val);
    case (idx)
      sacl_pkg::REG_WAYS:   ways_log2 = val[2:0];
      sacl_pkg::REG_OFFSET: offset_bits = val[2:0];
      sacl_pkg::REG_INDEX:  index_bits = val[4:0];
      default:              write_policy = val[1:0];
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // LRU age update: younger ways age by one, touched way becomes youngest
  function void age_touch(int unsigned base, int unsigned ways, int unsigned way);
    bit [3:0] a;
    a = ages[base + way];
    for (int unsigned w = 0; w < ways; w++)
      if (ages[base + w] < a) ages[base + w] = ages[base + w] + 4'd1;
    ages[base + way] = 0;
  endfunction

  function void note_input(sacl_pkg::in_item_t it);
    sacl_pkg::out_item_t r;
    int unsigned cnt, wl, ways, b, l, pol, off, nblk, blk, ba, set, base, way, n;
    bit          hit, found, is_wr;
    bit [3:0]    best;
    bit [29:0]   tag;
    r = '0;
    r.last = 1'b1;
    if (it.operation == sacl_pkg::OP_FLUSH) begin
      n = 0;
      for (int e = 0; e < sacl_pkg::TOTAL_ENTRIES; e++)
        if (valids[e] && dirties[e]) begin
          n++;
          dirties[e] = 0;
        end
      r.flushed_count = 17'(n);
      expected_q.push_back(r);
      return;
    end
    cnt = it.byte_count > 16 ? 16 : it.byte_count;
    if (it.operation == sacl_pkg::OP_NONE || cnt == 0) begin
      expected_q.push_back(r);
      return;
    end
    wl = ways_log2 > 4 ? 4 : ways_log2;
    ways = 1 << wl;
    b = offset_bits < 2 ? 2 : (offset_bits > 5 ? 5 : offset_bits);
    l = index_bits > 16 ? 16 : index_bits;
    if (l > 16 - wl) l = 16 - wl;
    pol = write_policy > sacl_pkg::POL_WT_NA ? sacl_pkg::POL_WT_NA : write_policy;
    is_wr = it.operation == sacl_pkg::OP_WRITE;
    off = it.address & ((1 << b) - 1);
    nblk = ((off + cnt - 1) >> b) + 1;
    blk = it.address >> b;
    for (int unsigned k = 0; k < nblk; k++) begin
      ba = (blk + k) & (32'hFFFF_FFFF >> b);
      set = ba & ((1 << l) - 1);
      tag = 30'(ba >> l);
      base = set * ways;
      r = '0;
      r.last = (k + 1 == nblk);
      r.memory_write = is_wr && pol != sacl_pkg::POL_WB;
      hit = 0;
      way = 0;
      for (int unsigned w = 0; w < ways; w++)
        if (!hit && valids[base + w] && tags[base + w] == tag) begin
          hit = 1;
          way = w;
        end
      if (hit) begin
        r.hit = 1;
        r.way_used = 4'(way);
        age_touch(base, ways, way);
        if (is_wr && pol == sacl_pkg::POL_WB) dirties[base + way] = 1;
      end else if (!(is_wr && pol == sacl_pkg::POL_WT_NA)) begin
        found = 0;
        for (int unsigned w = 0; w < ways; w++)
          if (!found && !valids[base + w]) begin
            found = 1;
            way = w;
          end
        if (!found) begin
          // oldest way; ties go to the lowest way
          best = ages[base];
          way = 0;
          for (int unsigned w = 1; w < ways; w++)
            if (ages[base + w] > best) begin
              best = ages[base + w];
              way = w;
            end
          r.replaced = 1;
          r.dirty_writeback = dirties[base + way];
        end
        r.allocated = 1;
        r.way_used = 4'(way);
        valids[base + way] = 1;
        tags[base + way] = tag;
        dirties[base + way] = is_wr && pol == sacl_pkg::POL_WB;
        age_touch(base, ways, way);
      end
      expected_q.push_back(r);
    end
  endfunction

  function void check(sacl_pkg::out_item_t act);
    sacl_pkg::out_item_t exp;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result %p", $time, act);
      errors++;
      return;
    end
    exp = expected_q.pop_front();
    if (act.hit != exp.hit || act.allocated != exp.allocated ||
        act.replaced != exp.replaced || act.dirty_writeback != exp.dirty_writeback ||
        act.memory_write != exp.memory_write || act.way_used != exp.way_used ||
        act.flushed_count != exp.flushed_count || act.last != exp.last) begin
      $display("%0t: mismatch expected %p actual %p", $time, exp, act);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 40000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  sacl_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_ready;
  sacl_pkg::out_item_t out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [sacl_pkg::CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cache_scoreboard sb;
  int          idle_in;
  int          idle_out;
  int          quiet_cycles;
  bit [31:0]   addr_pool[4];

  set_assoc_cache_lru_controller u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= idle_out);
  end

  // handshake monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("set_assoc_cache_lru_controller verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(int wl, int ob, int ib, int pol);
    // drop the last item and let the monitor note it before draining
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    reg_write(sacl_pkg::REG_WAYS, wl);
    reg_write(sacl_pkg::REG_OFFSET, ob);
    reg_write(sacl_pkg::REG_INDEX, ib);
    reg_write(sacl_pkg::REG_POLICY, pol);
  endtask

  task automatic send(logic [1:0] op, logic [31:0] addr, logic [4:0] cnt);
    while ($urandom_range(0, 99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, address: addr, byte_count: cnt};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    logic [1:0]  op;
    logic [31:0] addr;
    logic [4:0]  cnt;
    int          r;
    r = $urandom_range(0, 99);
    op = r < 3 ? sacl_pkg::OP_NONE : (r < 50 ? sacl_pkg::OP_READ : sacl_pkg::OP_WRITE);
    cnt = $urandom_range(0, 99) < 6 ? (($urandom_range(0, 1) != 0) ? 5'd0
          : 5'($urandom_range(17, 31))) : 5'($urandom_range(1, 16));
    if ($urandom_range(0, 9) == 0) addr = $urandom;
    else addr = addr_pool[$urandom_range(0, 3)] + $urandom_range(0, 1023);
    send(op, addr, cnt);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_in = 25;
    idle_out = 79;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(2, 2, 4, sacl_pkg::POL_WB);
        1: set_config(4, 5, 12, sacl_pkg::POL_WT);
        2: set_config(0, 2, 0, sacl_pkg::POL_WT_NA);
        3: set_config(1, 3, 3, sacl_pkg::POL_RSVD);
        4: set_config(7, 0, 31, sacl_pkg::POL_WB);
        default: set_config(3, 6, 5, sacl_pkg::POL_WT);
      endcase
      idle_in = ph < 2 ? 25 : (ph < 4 ? 79 : 0);
      idle_out = ph < 2 ? 79 : (ph < 4 ? 25 : 0);
      addr_pool[0] = 32'h0;
      addr_pool[1] = 32'hFFFF_FE00;
      addr_pool[2] = $urandom;
      addr_pool[3] = $urandom;
      if (ph == 0) begin
        send(sacl_pkg::OP_READ, 32'h0, 5'd1);
        send(sacl_pkg::OP_WRITE, 32'h0, 5'd16);
        send(sacl_pkg::OP_READ, 32'h3, 5'd16);
        send(sacl_pkg::OP_WRITE, 32'hFFFF_FFFE, 5'd16);   // wraps past the top
        send(sacl_pkg::OP_READ, 32'hFFFF_FFFF, 5'd1);
        send(sacl_pkg::OP_NONE, 32'h40, 5'd4);
        send(sacl_pkg::OP_READ, 32'h40, 5'd0);
        send(sacl_pkg::OP_WRITE, 32'h44, 5'd31);
        // same set, six tags: fills four ways then evicts a dirty line
        send(sacl_pkg::OP_WRITE, 32'h000, 5'd1);
        send(sacl_pkg::OP_WRITE, 32'h040, 5'd1);
        send(sacl_pkg::OP_WRITE, 32'h080, 5'd1);
        send(sacl_pkg::OP_READ, 32'h0C0, 5'd1);
        send(sacl_pkg::OP_READ, 32'h000, 5'd1);
        send(sacl_pkg::OP_WRITE, 32'h100, 5'd1);
        send(sacl_pkg::OP_READ, 32'h140, 5'd1);
        send(sacl_pkg::OP_FLUSH, 32'h0, 5'd0);
        send(sacl_pkg::OP_FLUSH, 32'hFFFF_FFFF, 5'd31);
        send(sacl_pkg::OP_READ, 32'h080, 5'd16);
      end
      for (int i = 0; i < 26; i++) send_random();
      if (ph % 2 == 1) send(sacl_pkg::OP_FLUSH, $urandom, 5'($urandom_range(0, 31)));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("set_assoc_cache_lru_controller verification clean");
    end else begin
      $display("set_assoc_cache_lru_controller verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/sacl_pkg.sv
hdl/sacl_fifo.sv
hdl/sacl_front.sv
hdl/sacl_back.sv
hdl/set_assoc_cache_lru_controller.sv
hdl/sacl_checker.sv
tb/sv/tb_top.sv
